/* rtl/core/plid_pkg.sv */
package plid_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 16;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned STAT_W = 2;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_DEL = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] entry_value;
      logic [STAT_W-1:0]        status;
      logic                     is_entry;
      logic                     list_empty;
      logic                     last_of_run;
   } res_type;

   typedef struct packed {
      logic re;
      logic we;
   } mem_ctl_type;

endpackage

/* rtl/core/plid_ram.sv */
module plid_ram import plid_pkg::*; #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  mem_ctl_type              ctl,
   input  logic [AW-1:0]            raddr,
   input  logic [AW-1:0]            waddr,
   input  logic signed [DATA_W-1:0] wdata,
   output logic signed [DATA_W-1:0] rdata
);

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   // Synchronous memory with a registered read port; the read data holds
   // while no read is issued.
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         store_ff[waddr] <= wdata;
      end
      if (ctl.re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/plid_seq.sv */
module plid_seq import plid_pkg::*; #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = $clog2(DEPTH),
   parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_content,
   output logic                     res_valid,
   input  logic                     res_ready,
   output res_type                  res,
   output mem_ctl_type              mem_ctl,
   output logic [AW-1:0]            mem_raddr,
   output logic [AW-1:0]            mem_waddr,
   output logic signed [DATA_W-1:0] mem_wdata,
   input  logic signed [DATA_W-1:0] mem_rdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE_NEW,
      ST_RESULT,
      ST_LIST_RD,
      ST_LIST_EMIT
   } state_type;

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            cur_ff, cur_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic signed [DATA_W-1:0] content_ff, content_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic                     empty_ff, empty_in;
   logic [CW-1:0]            clamp_pos;
   logic [CW-1:0]            rd_ptr;
   logic                     list_last;

   always_comb begin
      if (POS_W'(count_ff) < req_position) begin
         clamp_pos = count_ff;
      end else begin
         clamp_pos = req_position[CW-1:0];
      end
      if (kind_ff == KIND_INSERT) begin
         rd_ptr = cur_ff - CW'(1);
      end else begin
         rd_ptr = cur_ff + CW'(1);
      end
      list_last = ((cur_ff + CW'(1)) == count_ff);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      pos_in     = pos_ff;
      kind_in    = kind_ff;
      content_in = content_ff;
      status_in  = status_ff;
      empty_in   = empty_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      mem_ctl    = '0;
      mem_raddr  = cur_ff[AW-1:0];
      mem_waddr  = cur_ff[AW-1:0];
      mem_wdata  = mem_rdata;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               content_in = req_content;
               status_in  = STAT_DONE;
               empty_in   = 1'b0;
               case (req_kind)
                  KIND_INSERT: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = STAT_FULL;
                        state_in  = ST_RESULT;
                     end else begin
                        pos_in = clamp_pos;
                        cur_in = count_ff;
                        if (clamp_pos == count_ff) begin
                           state_in = ST_WRITE_NEW;
                        end else begin
                           state_in = ST_SHIFT_RD;
                        end
                     end
                  end
                  KIND_DELETE: begin
                     if (POS_W'(count_ff) <= req_position) begin
                        status_in = STAT_NO_DEL;
                        state_in  = ST_RESULT;
                     end else begin
                        pos_in = req_position[CW-1:0];
                        cur_in = req_position[CW-1:0];
                        if ((req_position[CW-1:0] + CW'(1)) == count_ff) begin
                           count_in = count_ff - CW'(1);
                           state_in = ST_RESULT;
                        end else begin
                           state_in = ST_SHIFT_RD;
                        end
                     end
                  end
                  KIND_LIST: begin
                     if (count_ff == '0) begin
                        empty_in = 1'b1;
                        state_in = ST_RESULT;
                     end else begin
                        cur_in   = '0;
                        state_in = ST_LIST_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SHIFT_RD: begin
            mem_ctl.re = 1'b1;
            mem_raddr  = rd_ptr[AW-1:0];
            state_in   = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            mem_ctl.we = 1'b1;
            cur_in     = rd_ptr;
            if (kind_ff == KIND_INSERT) begin
               if (rd_ptr == pos_ff) begin
                  state_in = ST_WRITE_NEW;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               if ((rd_ptr + CW'(1)) == count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end
         end
         ST_WRITE_NEW: begin
            mem_ctl.we = 1'b1;
            mem_wdata  = content_ff;
            count_in   = count_ff + CW'(1);
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            res_valid       = 1'b1;
            res.status      = status_ff;
            res.list_empty  = empty_ff;
            res.last_of_run = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST_RD: begin
            mem_ctl.re = 1'b1;
            state_in   = ST_LIST_EMIT;
         end
         ST_LIST_EMIT: begin
            res_valid       = 1'b1;
            res.entry_value = mem_rdata;
            res.is_entry    = 1'b1;
            res.last_of_run = list_last;
            if (res_ready) begin
               if (list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in   = cur_ff + CW'(1);
                  state_in = ST_LIST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cur_ff     <= cur_in;
      pos_ff     <= pos_in;
      kind_ff    <= kind_in;
      content_ff <= content_in;
      status_ff  <= status_in;
      empty_ff   <= empty_in;
   end

endmodule

/* rtl/core/positional_list_insert_delete.sv */
// Ordered list of up to DEPTH signed 32-bit values kept in one synchronous
// memory. Requests arrive on the req_ channel (valid/ready); each transfer
// carries a kind (insert, delete or list), a position and a value. Results
// leave on the rsp_ channel (valid/ready) from an output register; the last
// result of each request carries rsp_last_of_run. An unused kind is dropped
// without a result.
// The block handles one request at a time. An insert or a delete at
// position p shifts the entries behind p one per memory read and write
// state pair. A list request reads each entry from memory and hands it to
// the output register before reading the next. A request rejected as full
// or as nothing to delete goes straight to its result. Results are
// registered and appear in the cycle after hand-off.
// When the receiver stalls, the output register holds its transfer and the
// sequencer holds its next result, taking no request until it is handed off.
// Reset empties the list at once; the memory itself is not cleared, since
// entries at or above the count are never read.
module positional_list_insert_delete import plid_pkg::*; #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_content,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_entry_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_is_entry,
   output logic                     rsp_list_empty,
   output logic                     rsp_last_of_run
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic                     res_valid;
   logic                     res_ready;
   res_type                  res;
   mem_ctl_type              mem_ctl;
   logic [AW-1:0]            mem_raddr;
   logic [AW-1:0]            mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic signed [DATA_W-1:0] mem_rdata;
   logic                     rsp_valid_ff;
   res_type                  rsp_ff;

   // Sequencer: decodes each request and walks the memory one entry at a
   // time to shift, fill or read out the list.
   plid_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_content  (req_content),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .mem_ctl      (mem_ctl),
      .mem_raddr    (mem_raddr),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_rdata    (mem_rdata)
   );

   plid_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .ctl   (mem_ctl),
      .raddr (mem_raddr),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // The output register takes a new result whenever it is empty or its
   // current transfer completes in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_ff.entry_value;
   assign rsp_status      = rsp_ff.status;
   assign rsp_is_entry    = rsp_ff.is_entry;
   assign rsp_list_empty  = rsp_ff.list_empty;
   assign rsp_last_of_run = rsp_ff.last_of_run;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

import plid_pkg::*;

// Tracks the list contents that the block ought to hold and the results that
// it still owes, oldest first.
class list_scoreboard;
   int capacity;
   logic signed [DATA_W-1:0] held_values[$];
   res_type owed_results[$];
   int errors;
   int requests;
   int results;
   int full_drops;
   int missed_deletes;
   int empty_lists;
   int peak_fill;

   function new(int depth);
      capacity = depth;
      errors = 0;
      requests = 0;
      results = 0;
      full_drops = 0;
      missed_deletes = 0;
      empty_lists = 0;
      peak_fill = 0;
   endfunction

   function int pending();
      return owed_results.size();
   endfunction

   function int fill();
      return held_values.size();
   endfunction

   // Applies one accepted request to the list and queues what it must produce.
   function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                              logic signed [DATA_W-1:0] content);
      res_type r;
      int place;
      int n;
      r = '0;
      r.last_of_run = 1'b1;
      n = held_values.size();
      case (kind)
         KIND_INSERT: begin
            requests++;
            if (n >= capacity) begin
               r.status = STAT_FULL;
               full_drops++;
            end else begin
               place = (int'(position) > n) ? n : int'(position);
               held_values.insert(place, content);
            end
            owed_results.push_back(r);
         end
         KIND_DELETE: begin
            requests++;
            if (int'(position) >= n) begin
               r.status = STAT_NO_DEL;
               missed_deletes++;
            end else begin
               held_values.delete(int'(position));
            end
            owed_results.push_back(r);
         end
         KIND_LIST: begin
            requests++;
            if (n == 0) begin
               r.list_empty = 1'b1;
               empty_lists++;
               owed_results.push_back(r);
            end else begin
               for (int i = 0; i < n; i++) begin
                  r.entry_value = held_values[i];
                  r.is_entry = 1'b1;
                  r.last_of_run = (i == n - 1);
                  owed_results.push_back(r);
               end
            end
         end
         default: ;
      endcase
      if (held_values.size() > peak_fill) peak_fill = held_values.size();
   endfunction

   function void compare_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         if (errors <= 100)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function void check_result(res_type got);
      res_type want;
      results++;
      if (owed_results.size() == 0) begin
         errors++;
         if (errors <= 100)
            $display("%0t: result with none expected, expected nothing, got value %0d status %0d",
                     $time, got.entry_value, got.status);
         return;
      end
      want = owed_results.pop_front();
      compare_field("entry_value", want.entry_value, got.entry_value);
      compare_field("status", want.status, got.status);
      compare_field("is_entry", want.is_entry, got.is_entry);
      compare_field("list_empty", want.list_empty, got.list_empty);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
   endfunction
endclass

module tb_top;

   localparam int unsigned DEPTH = 32;
   // An unused request code; the block must swallow it without a result.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   // Quiet cycles allowed after the last result, covering the longest shift.
   localparam int SETTLE_CYCLES = 4 * DEPTH + 10;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 75;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [KIND_W-1:0]        req_kind;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_content;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_entry_value;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_is_entry;
   logic                     rsp_list_empty;
   logic                     rsp_last_of_run;

   // Idling controls, written by the stimulus process only.
   int send_idle_pct;
   int recv_stall_pct;
   int hold_requests;
   // Owned by the receiver process.
   int hold_served;
   int hold_left;

   list_scoreboard sb;

   positional_list_insert_delete #(.DEPTH(DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_content     (req_content),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_value (rsp_entry_value),
      .rsp_status      (rsp_status),
      .rsp_is_entry    (rsp_is_entry),
      .rsp_list_empty  (rsp_list_empty),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: even the slowest legal run finishes well inside this.
   initial begin
      #10_000_000;
      $display("positional_list_insert_delete test failed");
      $finish;
   end

   // Both channels are observed at the rising edge. A request transfer is
   // noted before any result of the same edge is checked; a result that
   // completes at that edge always belongs to an earlier request, which is
   // already queued ahead of the new one.
   always @(posedge clock) begin
      res_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_kind, req_position, req_content);
         if (rsp_valid && rsp_ready) begin
            got.entry_value = rsp_entry_value;
            got.status = rsp_status;
            got.is_entry = rsp_is_entry;
            got.list_empty = rsp_list_empty;
            got.last_of_run = rsp_last_of_run;
            sb.check_result(got);
         end
      end
   end

   // Receiver: stalls at random at the current rate, and on request holds
   // ready low for a long stretch so that the block backs up into its input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one request, with a random gap before it at the current idle
   // rate, and returns at the falling edge after its transfer. Valid is left
   // high so that back-to-back requests need no dead cycle.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] position,
                            input logic signed [DATA_W-1:0] content);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_position = position;
      req_content = content;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every owed result has arrived, then lets
   // the block finish any shift still under way.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Grows or shrinks the list in alternating stretches, so that both the
   // full and the empty list are visited again and again.
   function automatic logic [KIND_W-1:0] pick_kind(bit growing);
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) return KIND_UNUSED;
      if (growing) begin
         if (roll < 75) return KIND_INSERT;
         if (roll < 88) return KIND_DELETE;
         return KIND_LIST;
      end
      if (roll < 25) return KIND_INSERT;
      if (roll < 80) return KIND_DELETE;
      return KIND_LIST;
   endfunction

   // Mostly positions around the live part of the list, including one past
   // its end; now and then anything the field can carry.
   function automatic logic [POS_W-1:0] pick_position(int fill);
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return POS_W'($urandom_range(0, fill + 1));
      if (roll < 75) return POS_W'(fill);
      if (roll < 85) return POS_W'((fill == 0) ? 0 : fill - 1);
      return POS_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_content();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return 32'sh7FFF_FFFF;
      if (roll < 16) return 32'sh8000_0000;
      if (roll < 22) return '0;
      if (roll < 28) return -32'sd1;
      return $urandom;
   endfunction

   // Random requests; ignored codes do not count towards the total. Half way
   // through, the sender pauses until the block has caught up completely.
   task automatic run_random(input int count);
      int done;
      logic [KIND_W-1:0] kind;
      done = 0;
      while (done < count) begin
         kind = pick_kind(((done / 24) % 2) == 0);
         send_item(kind, pick_position(sb.fill()), pick_content());
         if (kind != KIND_UNUSED) done++;
         if (done == count / 2 && kind != KIND_UNUSED) wait_drained();
      end
   endtask

   initial begin
      sb = new(DEPTH);
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_INSERT;
      req_position = '0;
      req_content = '0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part: the empty list, clamped and edge positions, extreme
      // values, deletes at front, back and past the end, and an unused code.
      send_item(KIND_LIST, 16'd0, '0);
      send_item(KIND_DELETE, 16'd0, '0);
      send_item(KIND_DELETE, 16'hFFFF, 32'sh7FFF_FFFF);
      send_item(KIND_INSERT, 16'd0, 32'sh7FFF_FFFF);
      send_item(KIND_INSERT, 16'hFFFF, 32'sh8000_0000);
      send_item(KIND_INSERT, 16'd1, -32'sd1);
      send_item(KIND_INSERT, 16'd0, '0);
      send_item(KIND_LIST, 16'hFFFF, -32'sd1);
      send_item(KIND_UNUSED, 16'hFFFF, -32'sd1);
      send_item(KIND_DELETE, 16'd4, '0);
      send_item(KIND_DELETE, 16'd3, '0);
      send_item(KIND_DELETE, 16'd0, '0);
      send_item(KIND_DELETE, 16'd1, '0);
      send_item(KIND_LIST, 16'd0, '0);
      send_item(KIND_INSERT, 16'd2, 32'sd1234);
      send_item(KIND_LIST, 16'd0, '0);

      // Fill the list past its capacity so that inserts are refused, then
      // read it all back in one long run of results.
      repeat (DEPTH + 3) send_item(KIND_INSERT, POS_W'($urandom_range(0, 40)), $urandom);
      send_item(KIND_LIST, 16'd0, '0);
      wait_drained();

      // Phase one: neither side idles.
      run_random(PHASE_ITEMS);
      wait_drained();

      // Phase two: the sender idles often.
      send_idle_pct = 58;
      run_random(PHASE_ITEMS);
      wait_drained();

      // Phase three: the receiver stalls often.
      send_idle_pct = 0;
      recv_stall_pct = 58;
      run_random(PHASE_ITEMS);
      wait_drained();

      // Phase four: both sides idle now and then. It opens with a long
      // receiver hold-off while requests keep coming, so that the block
      // fills its output and refuses further transfers on its input.
      send_idle_pct = 12;
      recv_stall_pct = 12;
      hold_requests++;
      repeat (4) begin
         send_item(KIND_INSERT, pick_position(sb.fill()), pick_content());
         send_item(KIND_LIST, 16'd0, '0);
         send_item(KIND_DELETE, pick_position(sb.fill()), '0);
      end
      run_random(PHASE_ITEMS);
      wait_drained();

      $display("Covered %0d requests and %0d results, peak fill %0d of %0d.",
               sb.requests, sb.results, sb.peak_fill, DEPTH);
      $display("Saw %0d refused inserts, %0d deletes with no entry, %0d empty listings.",
               sb.full_drops, sb.missed_deletes, sb.empty_lists);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("positional_list_insert_delete test passed");
      end else begin
         $display("positional_list_insert_delete test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/plid_pkg.sv
rtl/core/plid_ram.sv
rtl/core/plid_seq.sv
rtl/core/positional_list_insert_delete.sv
sim/tb_top.sv
